FILE: hdl/framed_packet_receiver_assert.svh
// assertion macros used by the receiver parser module
`ifndef FRAMED_PACKET_RECEIVER_ASSERT_SVH
`define FRAMED_PACKET_RECEIVER_ASSERT_SVH

// plain property, sampled on clk, off while reset is asserted
`define FRP_ASSERT(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (prop)) else $error(msg);

// overlapping implication
`define FRP_ASSERT_IMP(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) else $error(msg);

// next-cycle implication
`define FRP_ASSERT_NXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) else $error(msg);

`endif

FILE: hdl/frp_pkg.sv
package frp_pkg;

	// header and token characters
	localparam logic [7:0] CH_U     = 8'h55;
	localparam logic [7:0] CH_N     = 8'h4E;
	localparam logic [7:0] CH_E     = 8'h45;
	localparam logic [7:0] CH_R     = 8'h52;
	localparam logic [7:0] CH_COLON = 8'h3A;

	// xor of the fixed header characters and the token
	localparam logic [7:0] HDR_XOR = CH_U ^ CH_N ^ CH_E ^ CH_R ^ CH_COLON;

	// tick count loaded by a start byte after reset
	localparam logic [7:0] RELOAD_AT_RESET = 8'd5;

	typedef enum logic [2:0] {
		ST_HUNT  = 3'd0,
		ST_N     = 3'd1,
		ST_E     = 3'd2,
		ST_R     = 3'd3,
		ST_LEN   = 3'd4,
		ST_TOKEN = 3'd5,
		ST_BODY  = 3'd6
	} parse_state_t;

	typedef struct packed {
		logic       mode;
		logic [7:0] rx_byte;
	} item_t;

	typedef struct packed {
		logic       payload_valid;
		logic [7:0] payload_byte;
		logic       is_command;
		logic       frame_done;
		logic       frame_good;
	} result_t;

endpackage

FILE: hdl/framed_packet_receiver.sv
// framed packet receiver
// input channel: in_valid / in_stall with mode and rx_byte; mode 0 carries a
// received byte, mode 1 a timeout tick. a request is taken at an edge with
// in_valid high and in_stall low.
// output channel: out_valid / out_stall with payload_valid, payload_byte,
// is_command, frame_done and frame_good; every request gives one result.
// config channel: cfg_valid / cfg_ready with timeout_reload; cfg_ready is
// always high; write it only while no request is in flight.
// pipeline: a taken request is held in the input register, then its result
// is loaded into the result register and shows on the outputs; one request
// per cycle is sustained while out_stall is low, the parser state updating
// as a request moves from the input register to the result register.
// reset: arst_n clears both registers' valid flags, puts the parser in the
// hunt for a start byte and sets the timeout reload register to 5.
// stall: while out_stall holds a full result register, the input register
// keeps its request and in_stall goes high; one request more can wait.
module framed_packet_receiver (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_stall,
	input  logic       mode,
	input  logic [7:0] rx_byte,
	output logic       out_valid,
	input  logic       out_stall,
	output logic       payload_valid,
	output logic [7:0] payload_byte,
	output logic       is_command,
	output logic       frame_done,
	output logic       frame_good,
	input  logic       cfg_valid,
	output logic       cfg_ready,
	input  logic [7:0] timeout_reload
);

	frp_pkg::item_t   item;
	frp_pkg::item_t   item_s1;
	frp_pkg::result_t res;
	frp_pkg::result_t res_q;
	logic             valid_s1;
	logic             advance;
	logic [7:0]       reload_q;

	assign item.mode    = mode;
	assign item.rx_byte = rx_byte;

	// timeout reload register
	assign cfg_ready = 1'b1;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			reload_q <= frp_pkg::RELOAD_AT_RESET;
		end else if (cfg_valid && cfg_ready) begin
			reload_q <= timeout_reload;
		end
	end

	frp_in_stage u_in (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_stall (in_stall),
		.item     (item),
		.advance  (advance),
		.valid_s1 (valid_s1),
		.item_s1  (item_s1)
	);

	frp_parser u_parser (
		.clk    (clk),
		.arst_n (arst_n),
		.step   (valid_s1 && advance),
		.item   (item_s1),
		.reload (reload_q),
		.res    (res)
	);

	frp_out_stage u_out (
		.clk       (clk),
		.arst_n    (arst_n),
		.valid_s1  (valid_s1),
		.res       (res),
		.advance   (advance),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.res_q     (res_q)
	);

	assign payload_valid = res_q.payload_valid;
	assign payload_byte  = res_q.payload_byte;
	assign is_command    = res_q.is_command;
	assign frame_done    = res_q.frame_done;
	assign frame_good    = res_q.frame_good;

endmodule

FILE: hdl/frp_in_stage.sv
module frp_in_stage (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            in_valid,
	output logic            in_stall,
	input  frp_pkg::item_t  item,
	input  logic            advance,
	output logic            valid_s1,
	output frp_pkg::item_t  item_s1
);

	logic            valid_q;
	frp_pkg::item_t  item_q;

	// the held request moves on whenever the result register can take it
	assign in_stall = valid_q && !advance;

	// request valid flag
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (!in_stall) begin
			valid_q <= in_valid;
		end
	end

	// request payload
	always_ff @(posedge clk) begin
		if (!in_stall && in_valid) begin
			item_q <= item;
		end
	end

	assign valid_s1 = valid_q;
	assign item_s1  = item_q;

endmodule

FILE: hdl/frp_parser.sv
`include "framed_packet_receiver_assert.svh"

module frp_parser (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              step,
	input  frp_pkg::item_t    item,
	input  logic [7:0]        reload,
	output frp_pkg::result_t  res
);

	frp_pkg::parse_state_t state_q, state_d;
	logic [7:0] bytes_left_q, bytes_left_d;
	logic [7:0] running_xor_q, running_xor_d;
	logic [7:0] ticks_left_q, ticks_left_d;
	logic       first_body_q, first_body_d;
	logic [7:0] b;
	logic [7:0] bl_dec;
	logic [7:0] tk_dec;
	logic       is_u;

	assign b      = item.rx_byte;
	assign is_u   = (b == frp_pkg::CH_U);
	assign bl_dec = bytes_left_q - 8'd1;
	assign tk_dec = ticks_left_q - 8'd1;

	// next state of the frame parser
	always_comb begin
		state_d       = state_q;
		bytes_left_d  = bytes_left_q;
		running_xor_d = running_xor_q;
		ticks_left_d  = ticks_left_q;
		first_body_d  = first_body_q;
		if (item.mode) begin
			// timeout tick
			if (state_q != frp_pkg::ST_HUNT) begin
				ticks_left_d = tk_dec;
				if (tk_dec == 8'd0) begin
					state_d = frp_pkg::ST_HUNT;
				end
			end
		end else begin
			case (state_q)
				frp_pkg::ST_HUNT: begin
					if (is_u) begin
						state_d      = frp_pkg::ST_N;
						ticks_left_d = reload;
					end
				end
				frp_pkg::ST_N: begin
					// a repeated start byte keeps waiting without a reload
					if (b == frp_pkg::CH_N) begin
						state_d = frp_pkg::ST_E;
					end else if (!is_u) begin
						state_d = frp_pkg::ST_HUNT;
					end
				end
				frp_pkg::ST_E: begin
					if (b == frp_pkg::CH_E) begin
						state_d = frp_pkg::ST_R;
					end else if (is_u) begin
						state_d      = frp_pkg::ST_N;
						ticks_left_d = reload;
					end else begin
						state_d = frp_pkg::ST_HUNT;
					end
				end
				frp_pkg::ST_R: begin
					if (b == frp_pkg::CH_R) begin
						state_d = frp_pkg::ST_LEN;
					end else if (is_u) begin
						state_d      = frp_pkg::ST_N;
						ticks_left_d = reload;
					end else begin
						state_d = frp_pkg::ST_HUNT;
					end
				end
				frp_pkg::ST_LEN: begin
					bytes_left_d = b;
					state_d      = frp_pkg::ST_TOKEN;
				end
				frp_pkg::ST_TOKEN: begin
					if (b == frp_pkg::CH_COLON) begin
						state_d       = frp_pkg::ST_BODY;
						running_xor_d = frp_pkg::HDR_XOR ^ bytes_left_q;
						first_body_d  = 1'b1;
					end else if (is_u) begin
						state_d      = frp_pkg::ST_N;
						ticks_left_d = reload;
					end else begin
						state_d = frp_pkg::ST_HUNT;
					end
				end
				frp_pkg::ST_BODY: begin
					bytes_left_d = bl_dec;
					first_body_d = 1'b0;
					if (bl_dec != 8'd0) begin
						running_xor_d = running_xor_q ^ b;
					end else begin
						state_d = frp_pkg::ST_HUNT;
					end
				end
				default: begin
					state_d = frp_pkg::ST_HUNT;
				end
			endcase
		end
	end

	// result fields for the current request
	always_comb begin
		res = '0;
		if (!item.mode && state_q == frp_pkg::ST_BODY) begin
			if (bl_dec != 8'd0) begin
				res.payload_valid = 1'b1;
				res.payload_byte  = b;
				res.is_command    = first_body_q;
			end else begin
				res.frame_done = 1'b1;
				res.frame_good = (b == running_xor_q);
			end
		end
	end

	// parser state registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q       <= frp_pkg::ST_HUNT;
			bytes_left_q  <= 8'd0;
			running_xor_q <= 8'd0;
			ticks_left_q  <= 8'd0;
			first_body_q  <= 1'b0;
		end else if (step) begin
			state_q       <= state_d;
			bytes_left_q  <= bytes_left_d;
			running_xor_q <= running_xor_d;
			ticks_left_q  <= ticks_left_d;
			first_body_q  <= first_body_d;
		end
	end

	// checks
	`FRP_ASSERT_NXT(a_hold_idle, !step, $stable(state_q) && $stable(bytes_left_q), "state moved without a request")
	`FRP_ASSERT_NXT(a_hunt_tick, step && item.mode && state_q == frp_pkg::ST_HUNT, $stable(ticks_left_q), "tick in hunt changed counter")
	`FRP_ASSERT_NXT(a_last_byte, step && !item.mode && state_q == frp_pkg::ST_BODY && bytes_left_q == 8'd1, state_q == frp_pkg::ST_HUNT, "frame did not close on checksum")
	`FRP_ASSERT_IMP(a_cmd_first, res.is_command, res.payload_valid && first_body_q, "command flag outside first body byte")

endmodule

FILE: hdl/frp_out_stage.sv
module frp_out_stage (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              valid_s1,
	input  frp_pkg::result_t  res,
	output logic              advance,
	output logic              out_valid,
	input  logic              out_stall,
	output frp_pkg::result_t  res_q
);

	logic out_valid_q;

	// result register can load when empty or being taken
	assign advance = !out_valid_q || !out_stall;

	// result valid flag
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= valid_s1;
		end
	end

	// result payload
	always_ff @(posedge clk) begin
		if (advance && valid_s1) begin
			res_q <= res;
		end
	end

	assign out_valid = out_valid_q;

endmodule
